### rtl/md5_message_digest_assert.svh
// assertion macros for the md5 message digest block
`ifndef MD5_MESSAGE_DIGEST_ASSERT_SVH
`define MD5_MESSAGE_DIGEST_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define MD5_ASSERT_IMPL(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("md5 assertion failed");

// implication checked in the next cycle
`define MD5_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("md5 assertion failed");

`endif

### rtl/md5_pkg.sv
// shared types, constants and functions of the md5 block
package md5_pkg;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;

  // datapath commands
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_PUT_BYTE,
    CMD_PAD,
    CMD_ROUND,
    CMD_ADD_CHAIN,
    CMD_CLEAR_BLOCK,
    CMD_LENGTH,
    CMD_RESTART
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [5:0] round;
    logic [7:0] data;
  } md5_cmd_t;

  typedef struct packed {
    logic [5:0] byte_position;
    logic       pos_wrapped;
  } md5_status_t;

  function automatic logic [31:0] round_const(input logic [5:0] r);
    logic [31:0] k;
    begin
      case (r)
        6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
        6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
        6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
        6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
        6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
        6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
        6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
        6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
        6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
        6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
        6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
        6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
        6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
        6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
        6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
        6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
        6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
        6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
        6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
        6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
        6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
        default: k = 32'heb86d391;
      endcase
      return k;
    end
  endfunction

  function automatic logic [4:0] rot_amount(input logic [3:0] i);
    logic [4:0] s;
    begin
      case (i)
        4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
        4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
        4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
        4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
      endcase
      return s;
    end
  endfunction

endpackage

### rtl/md5_if.sv
// valid/ready channel interfaces of the md5 block
interface md5_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       end_of_message;
  modport source (output valid, data_byte, byte_valid, end_of_message, input ready);
  modport sink (input valid, data_byte, byte_valid, end_of_message, output ready);
endinterface

interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

### rtl/md5_message_digest.sv
// top level of the md5 message digest block
// Takes one message byte per transfer and no new byte until it is stored; each 64th byte
// adds a compression of 64 rounds, one per cycle through a single round unit, plus
// control. The last transfer pads (one or two further compressions) and then offers the
// four digest words, first digest byte in the top bits, one per output transfer.
module md5_message_digest (
  input  logic      clk,
  input  logic      rst,
  md5_in_if.sink    in_ch,
  md5_out_if.source out_ch
);

  md5_pkg::md5_cmd_t    cmd;
  md5_pkg::md5_status_t status;
  logic [127:0]         chain;

  md5_control u_control (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .status (status),
    .chain  (chain),
    .cmd    (cmd)
  );

  md5_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .status (status),
    .chain  (chain)
  );

endmodule

### rtl/md5_datapath.sv
// md5 block store, round registers, chaining words and length counter
module md5_datapath (
  input  logic                clk,
  input  logic                rst,
  input  md5_pkg::md5_cmd_t   cmd,
  output md5_pkg::md5_status_t status,
  output logic [127:0]        chain
);

  logic [31:0] block_words [16];
  logic [31:0] chain_a, chain_b, chain_c, chain_d;
  logic [31:0] ra, rb, rc, rd;
  logic [63:0] message_bits;
  logic [5:0]  byte_position;

  logic [1:0]  phase;
  logic [31:0] f;
  logic [3:0]  g;
  logic [31:0] t;
  logic [31:0] rot;
  logic [4:0]  s;
  logic [3:0]  wsel;
  logic [1:0]  lane;
  logic [5:0]  pos_next;

  // round function of the current round
  always_comb begin
    phase = cmd.round[5:4];
    case (phase)
      2'd0: begin
        f = (rb & rc) | (~rb & rd);
        g = cmd.round[3:0];
      end
      2'd1: begin
        f = (rb & rd) | (rc & ~rd);
        g = 4'(5 * cmd.round[3:0] + 1);
      end
      2'd2: begin
        f = rb ^ rc ^ rd;
        g = 4'(3 * cmd.round[3:0] + 5);
      end
      default: begin
        f = rc ^ (rb | ~rd);
        g = 4'(7 * cmd.round[3:0]);
      end
    endcase
    s = md5_pkg::rot_amount({phase, cmd.round[1:0]});
    t = ra + f + block_words[g] + md5_pkg::round_const(cmd.round);
    rot = (t << s) | (t >> (6'd32 - {1'b0, s}));
    wsel = byte_position[5:2];
    lane = byte_position[1:0];
    pos_next = byte_position + 6'd1;
  end

  // block store writes
  always_ff @(posedge clk) begin
    case (cmd.op)
      md5_pkg::CMD_PUT_BYTE, md5_pkg::CMD_PAD: begin
        for (int i = 0; i < 16; i++) begin
          if (4'(i) == wsel) begin
            if (lane == 2'd0) begin
              block_words[i] <= {24'd0, cmd.data};
            end else begin
              block_words[i] <= block_words[i] | ({24'd0, cmd.data} << {lane, 3'b000});
            end
          end else if (cmd.op == md5_pkg::CMD_PAD && 4'(i) > wsel) begin
            block_words[i] <= '0;
          end
        end
      end
      md5_pkg::CMD_CLEAR_BLOCK: begin
        for (int i = 0; i < 16; i++) block_words[i] <= '0;
      end
      md5_pkg::CMD_LENGTH: begin
        block_words[14] <= message_bits[31:0];
        block_words[15] <= message_bits[63:32];
      end
      default: ;
    endcase
  end

  // control state and round registers
  always_ff @(posedge clk) begin
    if (rst || cmd.op == md5_pkg::CMD_RESTART) begin
      chain_a <= md5_pkg::InitA;
      chain_b <= md5_pkg::InitB;
      chain_c <= md5_pkg::InitC;
      chain_d <= md5_pkg::InitD;
      ra <= md5_pkg::InitA;
      rb <= md5_pkg::InitB;
      rc <= md5_pkg::InitC;
      rd <= md5_pkg::InitD;
      message_bits <= '0;
      byte_position <= '0;
    end else begin
      case (cmd.op)
        md5_pkg::CMD_PUT_BYTE: begin
          byte_position <= pos_next;
          message_bits <= message_bits + 64'd8;
        end
        md5_pkg::CMD_ROUND: begin
          ra <= rd;
          rd <= rc;
          rc <= rb;
          rb <= rb + rot;
        end
        md5_pkg::CMD_ADD_CHAIN: begin
          chain_a <= chain_a + ra;
          chain_b <= chain_b + rb;
          chain_c <= chain_c + rc;
          chain_d <= chain_d + rd;
          ra <= chain_a + ra;
          rb <= chain_b + rb;
          rc <= chain_c + rc;
          rd <= chain_d + rd;
        end
        default: ;
      endcase
    end
  end

  assign status.byte_position = byte_position;
  assign status.pos_wrapped = (byte_position == 6'd0);
  assign chain = {chain_a, chain_b, chain_c, chain_d};

endmodule

### rtl/md5_control.sv
// md5 sequencer: byte intake, padding, rounds and digest output
module md5_control (
  input  logic                 clk,
  input  logic                 rst,
  md5_in_if.sink               in_ch,
  md5_out_if.source            out_ch,
  input  md5_pkg::md5_status_t status,
  input  logic [127:0]         chain,
  output md5_pkg::md5_cmd_t    cmd
);

  `include "md5_message_digest_assert.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_PAD, S_ROUNDS, S_ADD, S_CLEAR, S_LENGTH, S_EMIT, S_RESTART
  } state_t;

  state_t      state;
  logic [5:0]  round;
  logic        pending_end;
  logic        final_block;
  logic [1:0]  word_index;
  logic [31:0] sel;

  assign in_ch.ready = (state == S_IDLE);

  // command decode
  always_comb begin
    cmd.op = md5_pkg::CMD_NONE;
    cmd.round = round;
    cmd.data = in_ch.data_byte;
    unique case (state)
      S_IDLE: begin
        if (in_ch.valid && in_ch.byte_valid) cmd.op = md5_pkg::CMD_PUT_BYTE;
      end
      S_PAD: begin
        cmd.op = md5_pkg::CMD_PAD;
        cmd.data = 8'h80;
      end
      S_ROUNDS: cmd.op = md5_pkg::CMD_ROUND;
      S_ADD: cmd.op = md5_pkg::CMD_ADD_CHAIN;
      S_CLEAR: cmd.op = md5_pkg::CMD_CLEAR_BLOCK;
      S_LENGTH: cmd.op = md5_pkg::CMD_LENGTH;
      S_RESTART: cmd.op = md5_pkg::CMD_RESTART;
      default: ;
    endcase
  end

  always_comb begin
    case (word_index)
      2'd0: sel = chain[127:96];
      2'd1: sel = chain[95:64];
      2'd2: sel = chain[63:32];
      default: sel = chain[31:0];
    endcase
  end

  // state and registered controls
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      round <= '0;
      pending_end <= 1'b0;
      final_block <= 1'b0;
      word_index <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            pending_end <= in_ch.end_of_message;
            if (in_ch.byte_valid) begin
              state <= S_CHECK;
            end else if (in_ch.end_of_message) begin
              state <= S_PAD;
            end
          end
        end
        S_CHECK: begin
          final_block <= 1'b0;
          round <= '0;
          if (status.pos_wrapped) begin
            state <= S_ROUNDS;
          end else if (pending_end) begin
            state <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_PAD: begin
          round <= '0;
          if (status.byte_position > 6'd55) begin
            final_block <= 1'b0;
            pending_end <= 1'b0;
            state <= S_ROUNDS;
          end else begin
            final_block <= 1'b1;
            state <= S_LENGTH;
          end
        end
        S_LENGTH: state <= S_ROUNDS;
        S_ROUNDS: begin
          round <= round + 6'd1;
          if (round == 6'd63) state <= S_ADD;
        end
        S_ADD: begin
          if (final_block) begin
            word_index <= '0;
            out_ch.valid <= 1'b1;
            state <= S_EMIT;
          end else if (pending_end) begin
            state <= S_PAD;
          end else begin
            state <= S_CLEAR;
          end
        end
        // block cleared; if padding spilled into an extra block, the length block follows
        S_CLEAR: begin
          if (status.byte_position > 6'd55) begin
            final_block <= 1'b1;
            round <= '0;
            state <= S_LENGTH;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_ch.ready) begin
            word_index <= word_index + 2'd1;
            if (word_index == 2'd3) begin
              out_ch.valid <= 1'b0;
              state <= S_RESTART;
            end
          end
        end
        S_RESTART: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.digest_word = {sel[7:0], sel[15:8], sel[23:16], sel[31:24]};
  assign out_ch.word_index = word_index;
  assign out_ch.last_word = (word_index == 2'd3);

  `MD5_ASSERT_IMPL(a_no_ready_busy, clk, rst, state != S_IDLE, !in_ch.ready)
  `MD5_ASSERT_NEXT(a_rounds_end, clk, rst, state == S_ROUNDS && round == 6'd63, state == S_ADD)
  `MD5_ASSERT_IMPL(a_emit_valid, clk, rst, state == S_EMIT, out_ch.valid)

endmodule
